FILE: design/aeloop_pkg.sv
// Shared types, widths and constants for the auto exposure loop.
package aeloop_pkg;

  localparam int MEAN_W   = 16;
  localparam int ISO_W    = 16;
  localparam int SH_W     = 30;
  localparam int STEP_W   = 4;
  localparam int COMP_W   = 8;
  localparam int SUM_W    = MEAN_W + 2;
  localparam int D_W      = 19;
  localparam int DS_W     = D_W + 1;
  localparam int TRIPLE_W = SH_W + 2;
  localparam int SCALE_SH = 15;
  localparam int NUM_W    = TRIPLE_W + SCALE_SH;
  localparam int REM_W    = D_W + 1;
  localparam int CNT_W    = 6;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic [D_W-1:0]  D_FLOOR   = D_W'(12288);
  localparam logic [D_W-1:0]  SCALE_NUM = D_W'(98304);

  localparam logic [ISO_W-1:0]  ISO_FLOOR_RST  = ISO_W'(100);
  localparam logic [ISO_W-1:0]  ISO_CEIL_RST   = ISO_W'(1000);
  localparam logic [SH_W-1:0]   SH_FLOOR_RST   = SH_W'(16000000);
  localparam logic [SH_W-1:0]   SH_CEIL_RST    = SH_W'(80000000);
  localparam logic [STEP_W-1:0] STEP_RST       = STEP_W'(2);
  localparam logic [COMP_W-1:0] COMP_RST       = 8'hC0;

  typedef enum logic [2:0] {
    REG_ISO_FLOOR = 3'd0,
    REG_ISO_CEIL  = 3'd1,
    REG_SH_FLOOR  = 3'd2,
    REG_SH_CEIL   = 3'd3,
    REG_STEP      = 3'd4,
    REG_COMP      = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_DIV,
    S_DONE
  } state_t;

endpackage

FILE: design/aeloop_in_if.sv
// Input channel: three channel means of one frame per beat.
interface aeloop_in_if import aeloop_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MEAN_W-1:0] mean_red;
  logic [MEAN_W-1:0] mean_green;
  logic [MEAN_W-1:0] mean_blue;

  modport source(output valid, mean_red, mean_green, mean_blue, input ready);
  modport sink(input valid, mean_red, mean_green, mean_blue, output ready);
endinterface

FILE: design/aeloop_out_if.sv
// Result channel: exposure settings in force after each frame.
interface aeloop_out_if import aeloop_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ISO_W-1:0] iso_now;
  logic [SH_W-1:0]  shutter_now_ns;
  logic             night_mode;
  logic             adjusted;

  modport source(output valid, iso_now, shutter_now_ns, night_mode, adjusted, input ready);
  modport sink(input valid, iso_now, shutter_now_ns, night_mode, adjusted, output ready);
endinterface

FILE: design/auto_exposure_shutter_iso_loop.sv
// Auto exposure loop: shutter then ISO update per frame, bit-serial divide.
// A frame that divides goes through a setup state, 47 restoring-divide steps and
// a clamp state before its result is loaded; skipped, black and shutter-off-ceiling
// frames go from the setup state straight to the clamp state.
// Throughput: one frame at a time, a beat being accepted only when idle; the divider
// yields one quotient bit per cycle. Synchronous active-low reset restores the
// register defaults, ISO 100, shutter 16000000 ns and a zero skip count.
module auto_exposure_shutter_iso_loop import aeloop_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  aeloop_in_if.sink         in_ch,
  aeloop_out_if.source      out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [ISO_W-1:0]  iso_floor_r, iso_ceil_r;
  logic [SH_W-1:0]   sh_floor_r, sh_ceil_r;
  logic [STEP_W-1:0] step_r;
  logic [COMP_W-1:0] comp_r;

  state_t state_r, state_nxt;

  logic [MEAN_W-1:0] red_r, green_r, blue_r;
  logic [STEP_W-1:0] skip_r;
  logic [ISO_W-1:0]  iso_r, cand_iso_r;
  logic [SH_W-1:0]   sh_r, cand_sh_r;
  logic [D_W-1:0]    d_r;
  logic              adj_r, use_div_r, div_sh_r;
  logic [NUM_W-1:0]  num_r;
  logic [REM_W-1:0]  rem_r;
  logic [CNT_W-1:0]  cnt_r;

  logic              out_valid_r;
  logic [ISO_W-1:0]  out_iso_r;
  logic [SH_W-1:0]   out_sh_r;
  logic              out_night_r, out_adj_r;

  logic                     cfg_wr;
  logic [2:0]               cfg_idx;
  logic                     in_fire, out_free, out_load;
  logic [SUM_W-1:0]         sum;
  logic signed [DS_W-1:0]   comp_ext, comp_x768, d_raw;
  logic [D_W-1:0]           d_fl;
  logic                     black;
  logic                     div_sh_pick;
  logic [TRIPLE_W-1:0]      tri_src, triple;
  logic [REM_W-1:0]         rem_sh;
  logic                     ge;
  logic [NUM_W-1:0]         iso_pre, iso_lo, iso_hi, sh_pre, sh_lo, sh_hi;
  logic [ISO_W-1:0]         iso_new;
  logic [SH_W-1:0]          sh_new;

  // Config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iso_floor_r <= ISO_FLOOR_RST;
      iso_ceil_r  <= ISO_CEIL_RST;
      sh_floor_r  <= SH_FLOOR_RST;
      sh_ceil_r   <= SH_CEIL_RST;
      step_r      <= STEP_RST;
      comp_r      <= COMP_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ISO_FLOOR: iso_floor_r <= pwdata[ISO_W-1:0];
        REG_ISO_CEIL:  iso_ceil_r  <= pwdata[ISO_W-1:0];
        REG_SH_FLOOR:  sh_floor_r  <= pwdata[SH_W-1:0];
        REG_SH_CEIL:   sh_ceil_r   <= pwdata[SH_W-1:0];
        REG_STEP:      step_r      <= pwdata[STEP_W-1:0];
        REG_COMP:      comp_r      <= pwdata[COMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ISO_FLOOR: prdata = DATA_W'(iso_floor_r);
      REG_ISO_CEIL:  prdata = DATA_W'(iso_ceil_r);
      REG_SH_FLOOR:  prdata = DATA_W'(sh_floor_r);
      REG_SH_CEIL:   prdata = DATA_W'(sh_ceil_r);
      REG_STEP:      prdata = DATA_W'(step_r);
      REG_COMP:      prdata = DATA_W'(comp_r);
      default:       prdata = '0;
    endcase
  end

  // Handshakes
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign out_load    = (state_r == S_DONE) && out_free;

  // Setup-cycle arithmetic
  assign sum       = SUM_W'(red_r) + SUM_W'(green_r) + SUM_W'(blue_r);
  assign comp_ext  = DS_W'($signed(comp_r));
  assign comp_x768 = (comp_ext <<< 9) + (comp_ext <<< 8);
  assign d_raw     = $signed({2'b00, sum}) - comp_x768;
  assign d_fl      = (d_raw < $signed({1'b0, D_FLOOR})) ? D_FLOOR : d_raw[D_W-1:0];
  assign black     = (red_r == '0) && (green_r == '0) && (blue_r == '0);
  assign div_sh_pick = (sh_r != sh_ceil_r);
  assign tri_src   = div_sh_pick ? TRIPLE_W'(sh_r) : TRIPLE_W'(iso_r);
  assign triple    = tri_src + {tri_src[TRIPLE_W-2:0], 1'b0};

  // Divider step
  assign rem_sh = {rem_r[REM_W-2:0], num_r[NUM_W-1]};
  assign ge     = (rem_sh >= REM_W'(d_r));

  // Clamp
  assign iso_pre = (use_div_r && !div_sh_r) ? num_r : NUM_W'(cand_iso_r);
  assign iso_lo  = (iso_pre < NUM_W'(iso_floor_r)) ? NUM_W'(iso_floor_r) : iso_pre;
  assign iso_hi  = (iso_lo > NUM_W'(iso_ceil_r)) ? NUM_W'(iso_ceil_r) : iso_lo;
  assign sh_pre  = (use_div_r && div_sh_r) ? num_r : NUM_W'(cand_sh_r);
  assign sh_lo   = (sh_pre < NUM_W'(sh_floor_r)) ? NUM_W'(sh_floor_r) : sh_pre;
  assign sh_hi   = (sh_lo > NUM_W'(sh_ceil_r)) ? NUM_W'(sh_ceil_r) : sh_lo;
  assign iso_new = adj_r ? iso_hi[ISO_W-1:0] : iso_r;
  assign sh_new  = adj_r ? sh_hi[SH_W-1:0] : sh_r;

  // FSM
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_CALC;
      end
      S_CALC: begin
        if (skip_r != '0 || black) begin
          state_nxt = S_DONE;
        end else if (!div_sh_pick && iso_r == iso_floor_r && d_fl > SCALE_NUM) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt_r == CNT_W'(NUM_W - 1)) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= '0;
      iso_r  <= ISO_FLOOR_RST;
      sh_r   <= SH_FLOOR_RST;
      adj_r  <= 1'b0;
    end else begin
      if (state_r == S_CALC) begin
        if (skip_r != '0) begin
          skip_r <= skip_r - STEP_W'(1);
          adj_r  <= 1'b0;
        end else if (black) begin
          adj_r <= 1'b0;
        end else begin
          skip_r <= step_r;
          adj_r  <= 1'b1;
        end
      end
      if (out_load) begin
        iso_r <= iso_new;
        sh_r  <= sh_new;
      end
    end
  end

  // Datapath payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      red_r   <= in_ch.mean_red;
      green_r <= in_ch.mean_green;
      blue_r  <= in_ch.mean_blue;
    end
    if (state_r == S_CALC) begin
      d_r        <= d_fl;
      div_sh_r   <= div_sh_pick;
      num_r      <= {triple, SCALE_SH'(0)};
      rem_r      <= '0;
      cnt_r      <= '0;
      cand_iso_r <= div_sh_pick ? iso_floor_r : iso_r;
      if (!div_sh_pick && iso_r == iso_floor_r && d_fl > SCALE_NUM) begin
        use_div_r <= 1'b0;
        cand_sh_r <= (sh_ceil_r == '0) ? '0 : sh_ceil_r - SH_W'(1);
      end else begin
        use_div_r <= 1'b1;
        cand_sh_r <= sh_r;
      end
    end
    if (state_r == S_DIV) begin
      rem_r <= ge ? (rem_sh - REM_W'(d_r)) : rem_sh;
      num_r <= {num_r[NUM_W-2:0], ge};
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_iso_r   <= iso_new;
      out_sh_r    <= sh_new;
      out_night_r <= (sh_new == sh_ceil_r);
      out_adj_r   <= adj_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.iso_now        = out_iso_r;
  assign out_ch.shutter_now_ns = out_sh_r;
  assign out_ch.night_mode     = out_night_r;
  assign out_ch.adjusted       = out_adj_r;

  // Assertions
  a_accept_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_CALC)
    else $error("accepted beat did not start setup");

  a_done_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && state_r == S_IDLE)
    else $error("result not loaded on completion");

  a_step_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CALC && skip_r == '0 && !black) |=> skip_r == step_r && adj_r)
    else $error("skip count not reloaded on adjusting frame");

  a_shutter_window: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && adj_r && sh_floor_r <= sh_ceil_r) |=>
      (sh_r >= sh_floor_r) && (sh_r <= sh_ceil_r))
    else $error("shutter left its window");

endmodule
